[design/sts_pkg.sv]
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, codes and character helpers for the S-expression token
// scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int unsigned LINE_WIDTH_DEFAULT   = 24;
  localparam int unsigned COLUMN_WIDTH_DEFAULT = 16;

  // Most results one source byte can produce, and result queue depth.
  localparam int unsigned MaxRes   = 3;
  localparam int unsigned ResDepth = 4;

  typedef enum logic [3:0] {
    KIND_OPEN   = 4'd0,
    KIND_CLOSE  = 4'd1,
    KIND_COMMA  = 4'd2,
    KIND_QUOTE  = 4'd3,
    KIND_PERIOD = 4'd4,
    KIND_STRING = 4'd5,
    KIND_INT    = 4'd6,
    KIND_FLOAT  = 4'd7,
    KIND_SYMBOL = 4'd8,
    KIND_EOF    = 4'd9,
    KIND_BAD    = 4'd10
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_UNKNOWN_CHAR = 3'd1,
    ERR_NL_IN_STRING = 3'd2,
    ERR_BAD_ESCAPE   = 3'd3,
    ERR_UNTERMINATED = 3'd4,
    ERR_SECOND_DOT   = 3'd5
  } err_e;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [7:0]  char_value;
    logic        has_char;
    logic        token_last;
    logic [23:0] token_line;
    logic [15:0] token_column;
    logic [2:0]  error_code;
  } out_beat_t;

  // Results produced by one accepted byte, oldest in slot 0.
  typedef struct packed {
    logic [1:0]                   count;
    out_beat_t [MaxRes-1:0]       res;
  } push_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // NUL and the delimiter set never belong to a symbol.
  function automatic logic is_symbol_char(logic [7:0] b);
    return !(b inside {8'h00, 8'h20, 8'h09, 8'h0A, 8'h0D, 8'h28, 8'h29, 8'h5B, 8'h5D,
                       8'h22, 8'h3B, 8'h2C, 8'h27, 8'h7C, 8'h5C, 8'h23});
  endfunction

  function automatic out_beat_t make_res(kind_e kind, logic [7:0] ch, logic has,
                                         logic last, logic [23:0] line,
                                         logic [15:0] col, err_e err);
    out_beat_t r;
    r.token_kind   = kind;
    r.char_value   = ch;
    r.has_char     = has;
    r.token_last   = last;
    r.token_line   = line;
    r.token_column = col;
    r.error_code   = err;
    return r;
  endfunction

endpackage

[design/sts_core.sv]
// ----------------------------------------------------------------------------
// sts_core
// Scanner state and the per-byte step: classifies one byte against the
// current mode and produces up to three results.
// ----------------------------------------------------------------------------
module sts_core import sts_pkg::*; #(
  parameter int unsigned LINE_WIDTH   = LINE_WIDTH_DEFAULT,
  parameter int unsigned COLUMN_WIDTH = COLUMN_WIDTH_DEFAULT
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_beat_t beat_i,
  output push_t    push_o
);

  typedef enum logic [2:0] {
    M_IDLE, M_COMMENT, M_STRING, M_ESCAPE, M_NUMBER, M_SYMBOL, M_DOT, M_MINUS
  } mode_e;

  mode_e                   mode_q, mode_d;
  logic                    dot_q, dot_d;
  logic                    fin_q, fin_d;
  logic [LINE_WIDTH-1:0]   line_q, line_d, sline_q, sline_d;
  logic [COLUMN_WIDTH-1:0] col_q, col_d, scol_q, scol_d;

  logic [7:0]  b;
  logic        do_idle;
  logic [1:0]  n;
  out_beat_t [MaxRes-1:0] res;
  logic [23:0] cur_line, st_line;
  logic [15:0] cur_col, st_col;
  logic [7:0]  esc_ch;
  err_e        esc_err;
  kind_e       num_kind;

  assign b        = beat_i.end_of_input ? 8'h00 : beat_i.source_byte;
  assign cur_line = 24'(line_q);
  assign cur_col  = 16'(col_q);
  assign st_line  = 24'(sline_q);
  assign st_col   = 16'(scol_q);
  assign num_kind = dot_q ? KIND_FLOAT : KIND_INT;

  // Escape decode
  always_comb begin
    esc_err = ERR_NONE;
    case (b)
      8'h6E:   esc_ch = 8'h0A;
      8'h74:   esc_ch = 8'h09;
      8'h72:   esc_ch = 8'h0D;
      8'h22:   esc_ch = 8'h22;
      8'h27:   esc_ch = 8'h27;
      8'h5C:   esc_ch = 8'h5C;
      default: begin
        esc_ch  = 8'h20;
        esc_err = ERR_BAD_ESCAPE;
      end
    endcase
  end

  always_comb begin
    mode_d  = mode_q;
    dot_d   = dot_q;
    fin_d   = fin_q;
    sline_d = sline_q;
    scol_d  = scol_q;
    do_idle = 1'b0;
    n       = '0;
    res     = '0;

    case (mode_q)
      M_COMMENT: begin
        if (b == 8'h00 || b == 8'h0A) do_idle = 1'b1;
      end
      M_STRING, M_ESCAPE: begin
        if (b == 8'h00) begin
          res[n] = make_res(KIND_STRING, 8'h00, 1'b0, 1'b1, st_line, st_col,
                            ERR_UNTERMINATED);
          n = n + 2'd1;
          do_idle = 1'b1;
        end else if (mode_q == M_ESCAPE) begin
          res[n] = make_res(KIND_STRING, esc_ch, 1'b1, 1'b0, st_line, st_col, esc_err);
          n = n + 2'd1;
          mode_d = M_STRING;
        end else if (b == 8'h22) begin
          res[n] = make_res(KIND_STRING, 8'h00, 1'b0, 1'b1, st_line, st_col, ERR_NONE);
          n = n + 2'd1;
          mode_d = M_IDLE;
        end else if (b == 8'h5C) begin
          mode_d = M_ESCAPE;
        end else begin
          res[n] = make_res(KIND_STRING, b, 1'b1, 1'b0, st_line, st_col,
                            (b == 8'h0A) ? ERR_NL_IN_STRING : ERR_NONE);
          n = n + 2'd1;
        end
      end
      M_NUMBER: begin
        if (is_digit(b)) begin
          res[n] = make_res(num_kind, b, 1'b1, 1'b0, st_line, st_col, ERR_NONE);
          n = n + 2'd1;
        end else if (b == 8'h2E) begin
          res[n] = make_res(KIND_FLOAT, b, 1'b1, 1'b0, st_line, st_col,
                            dot_q ? ERR_SECOND_DOT : ERR_NONE);
          n = n + 2'd1;
          dot_d = 1'b1;
        end else begin
          res[n] = make_res(num_kind, 8'h00, 1'b0, 1'b1, st_line, st_col, ERR_NONE);
          n = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      M_SYMBOL: begin
        if (is_symbol_char(b)) begin
          res[n] = make_res(KIND_SYMBOL, b, 1'b1, 1'b0, st_line, st_col, ERR_NONE);
          n = n + 2'd1;
        end else begin
          res[n] = make_res(KIND_SYMBOL, 8'h00, 1'b0, 1'b1, st_line, st_col, ERR_NONE);
          n = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      M_DOT: begin
        if (is_symbol_char(b)) begin
          res[n] = make_res(KIND_SYMBOL, 8'h2E, 1'b1, 1'b0, st_line, st_col, ERR_NONE);
          n = n + 2'd1;
          res[n] = make_res(KIND_SYMBOL, b, 1'b1, 1'b0, st_line, st_col, ERR_NONE);
          n = n + 2'd1;
          mode_d = M_SYMBOL;
        end else begin
          res[n] = make_res(KIND_PERIOD, 8'h00, 1'b0, 1'b1, st_line, st_col, ERR_NONE);
          n = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      M_MINUS: begin
        if (is_digit(b)) begin
          res[n] = make_res(KIND_INT, 8'h2D, 1'b1, 1'b0, st_line, st_col, ERR_NONE);
          n = n + 2'd1;
          res[n] = make_res(KIND_INT, b, 1'b1, 1'b0, st_line, st_col, ERR_NONE);
          n = n + 2'd1;
          mode_d = M_NUMBER;
          dot_d  = 1'b0;
        end else begin
          res[n] = make_res(KIND_SYMBOL, 8'h2D, 1'b1, 1'b0, st_line, st_col, ERR_NONE);
          n = n + 2'd1;
          if (is_symbol_char(b)) begin
            res[n] = make_res(KIND_SYMBOL, b, 1'b1, 1'b0, st_line, st_col, ERR_NONE);
            n = n + 2'd1;
            mode_d = M_SYMBOL;
          end else begin
            res[n] = make_res(KIND_SYMBOL, 8'h00, 1'b0, 1'b1, st_line, st_col, ERR_NONE);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
      end
      default: do_idle = 1'b1;
    endcase

    // Byte seen from the idle mode, after any pending token was closed.
    if (do_idle) begin
      mode_d = M_IDLE;
      case (b)
        8'h00: begin
          res[n] = make_res(KIND_EOF, 8'h00, 1'b0, 1'b1, cur_line, cur_col, ERR_NONE);
          n = n + 2'd1;
          fin_d = 1'b1;
        end
        8'h20, 8'h09, 8'h0D, 8'h0A: ;
        8'h28: begin
          res[n] = make_res(KIND_OPEN, 8'h00, 1'b0, 1'b1, cur_line, cur_col, ERR_NONE);
          n = n + 2'd1;
        end
        8'h29: begin
          res[n] = make_res(KIND_CLOSE, 8'h00, 1'b0, 1'b1, cur_line, cur_col, ERR_NONE);
          n = n + 2'd1;
        end
        8'h2C: begin
          res[n] = make_res(KIND_COMMA, 8'h00, 1'b0, 1'b1, cur_line, cur_col, ERR_NONE);
          n = n + 2'd1;
        end
        8'h27: begin
          res[n] = make_res(KIND_QUOTE, 8'h00, 1'b0, 1'b1, cur_line, cur_col, ERR_NONE);
          n = n + 2'd1;
        end
        8'h2E: begin
          mode_d  = M_DOT;
          sline_d = line_q;
          scol_d  = col_q;
        end
        8'h2D: begin
          mode_d  = M_MINUS;
          sline_d = line_q;
          scol_d  = col_q;
        end
        8'h3B: mode_d = M_COMMENT;
        8'h22: begin
          mode_d  = M_STRING;
          sline_d = line_q;
          scol_d  = col_q;
        end
        default: begin
          if (is_digit(b)) begin
            mode_d  = M_NUMBER;
            sline_d = line_q;
            scol_d  = col_q;
            dot_d   = 1'b0;
            res[n] = make_res(KIND_INT, b, 1'b1, 1'b0, cur_line, cur_col, ERR_NONE);
            n = n + 2'd1;
          end else if (is_symbol_char(b)) begin
            mode_d  = M_SYMBOL;
            sline_d = line_q;
            scol_d  = col_q;
            res[n] = make_res(KIND_SYMBOL, b, 1'b1, 1'b0, cur_line, cur_col, ERR_NONE);
            n = n + 2'd1;
          end else begin
            res[n] = make_res(KIND_BAD, b, 1'b1, 1'b1, cur_line, cur_col,
                              ERR_UNKNOWN_CHAR);
            n = n + 2'd1;
          end
        end
      endcase
    end

    // Position of the next byte; frozen once end of file is reached.
    line_d = line_q;
    col_d  = col_q;
    if (!fin_d) begin
      if (b == 8'h0A) begin
        if (line_q != '1) line_d = line_q + LINE_WIDTH'(1);
        col_d = '0;
      end else if (col_q != '1) begin
        col_d = col_q + COLUMN_WIDTH'(1);
      end
    end

    // A finished scanner ignores everything until reset.
    if (fin_q) begin
      mode_d  = mode_q;
      dot_d   = dot_q;
      fin_d   = fin_q;
      sline_d = sline_q;
      scol_d  = scol_q;
      line_d  = line_q;
      col_d   = col_q;
      n       = '0;
    end
  end

  assign push_o.count = accept_i ? n : 2'd0;
  assign push_o.res   = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      dot_q   <= 1'b0;
      fin_q   <= 1'b0;
      line_q  <= LINE_WIDTH'(1);
      col_q   <= '0;
      sline_q <= LINE_WIDTH'(1);
      scol_q  <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      dot_q   <= dot_d;
      fin_q   <= fin_d;
      line_q  <= line_d;
      col_q   <= col_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
    end
  end

endmodule

[design/sts_res_fifo.sv]
// ----------------------------------------------------------------------------
// sts_res_fifo
// Result queue: takes up to three results per cycle, hands out one beat per
// cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module sts_res_fifo import sts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  localparam int unsigned PtrW = $clog2(ResDepth);
  localparam int unsigned CntW = $clog2(ResDepth + 1);

  out_beat_t           mem_q [ResDepth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_beat_o  = mem_q[rd_q];
  // Room for a worst-case byte without looking at this cycle's pop.
  assign room_o      = (cnt_q <= CntW'(ResDepth - MaxRes));
  assign cnt_d       = cnt_q + CntW'(push_i.count) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (2'(i) < push_i.count) mem_q[wr_q + PtrW'(i)] <= push_i.res[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_i.count);
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

endmodule

[design/sexpr_token_scanner_top.sv]
// ----------------------------------------------------------------------------
// sexpr_token_scanner_top
// Streaming S-expression lexer, one source byte per input beat.
// ----------------------------------------------------------------------------
// One source byte is taken per clock unless the input stalls. Each byte is
// classified in the cycle it is accepted and its results (none to three)
// land in a four-entry registered result queue. The output moves one result
// per beat, so the sustained rate is one byte per cycle while the receiver
// does not stall and bytes yield at most one result each, which covers plain
// characters, whitespace and comments. A byte that yields two or three
// results (the resolution of a held '.' or '-', or a token end followed by a
// new token) costs one extra output beat per extra result, and the input
// stalls while more than one result waits in the queue. After the end-of-file
// token the scanner accepts and discards bytes until reset. Line and column
// counters are LINE_WIDTH and COLUMN_WIDTH bits and saturate; the reported
// fields carry their low 24 and 16 bits.
// ----------------------------------------------------------------------------
module sexpr_token_scanner_top import sts_pkg::*; #(
  parameter int unsigned LINE_WIDTH   = LINE_WIDTH_DEFAULT,
  parameter int unsigned COLUMN_WIDTH = COLUMN_WIDTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  // source byte channel
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  // token result channel
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic  room;
  logic  accept;
  push_t push;

  // stall only from registered queue fill, never from the output side
  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  sts_core #(
    .LINE_WIDTH  (LINE_WIDTH),
    .COLUMN_WIDTH(COLUMN_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .beat_i  (in_beat_i),
    .push_o  (push)
  );

  sts_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

endmodule

[dv/tb_sexpr_token_scanner_top.sv]
// ----------------------------------------------------------------------------
// tb_sexpr_token_scanner_top
// Self-checking bench for the streaming S-expression lexer. A scoreboard
// class runs its own lexer over every accepted source byte and checks each
// token beat field by field. The stimulus is one source text: a short
// hand-written opening, random tokens around a short fixed line, a random
// ending, then a few beats after end of file that must be swallowed.
// ----------------------------------------------------------------------------
module tb_sexpr_token_scanner_top;
  import sts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Lexer states of the scoreboard's own scanner.
  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_COMMENT,
    SCAN_STRING,
    SCAN_ESCAPE,
    SCAN_NUMBER,
    SCAN_SYMBOL,
    SCAN_DOT,
    SCAN_MINUS
  } scan_e;

  // --------------------------------------------------------------------------
  // Scoreboard: lexes each accepted byte and holds the token beats it owes.
  // --------------------------------------------------------------------------
  class token_scoreboard;
    scan_e       mode;
    bit          seen_dot;
    logic [23:0] line_cnt;
    logic [15:0] col_cnt;
    logic [23:0] tok_line;
    logic [15:0] tok_col;
    bit          done;
    out_beat_t   expected_tokens[$];
    int unsigned fail_cnt;

    function new();
      mode     = SCAN_IDLE;
      seen_dot = 1'b0;
      line_cnt = 24'd1;
      col_cnt  = '0;
      tok_line = 24'd1;
      tok_col  = '0;
      done     = 1'b0;
      fail_cnt = 0;
    endfunction

    function int unsigned pending();
      return expected_tokens.size();
    endfunction

    // Delimiters and NUL never belong to a symbol.
    function bit is_sym(logic [7:0] b);
      case (b)
        8'h00, " ", "\t", "\n", "\r", "(", ")", "[", "]", "\"", ";", ",", "'", "|",
        "\\", "#": return 1'b0;
        default: return 1'b1;
      endcase
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function void add(kind_e kind, logic [7:0] ch, logic has, logic last,
                      logic [23:0] ln, logic [15:0] cl, err_e err);
      out_beat_t r;
      r.token_kind   = kind;
      r.char_value   = ch;
      r.has_char     = has;
      r.token_last   = last;
      r.token_line   = ln;
      r.token_column = cl;
      r.error_code   = err;
      expected_tokens.push_back(r);
    endfunction

    function void value_char(kind_e kind, logic [7:0] ch, err_e err);
      add(kind, ch, 1'b1, 1'b0, tok_line, tok_col, err);
    endfunction

    function void value_end(kind_e kind, err_e err);
      add(kind, 8'h00, 1'b0, 1'b1, tok_line, tok_col, err);
      mode = SCAN_IDLE;
    endfunction

    function void begin_at(scan_e m, logic [23:0] ln, logic [15:0] cl);
      mode     = m;
      tok_line = ln;
      tok_col  = cl;
    endfunction

    function kind_e num_kind();
      if (seen_dot) return KIND_FLOAT;
      return KIND_INT;
    endfunction

    function void idle_byte(logic [7:0] b, logic [23:0] ln, logic [15:0] cl);
      mode = SCAN_IDLE;
      case (b)
        8'h00: begin
          add(KIND_EOF, 8'h00, 1'b0, 1'b1, ln, cl, ERR_NONE);
          done = 1'b1;
        end
        " ", "\t", "\r", "\n": ;
        "(":  add(KIND_OPEN, 8'h00, 1'b0, 1'b1, ln, cl, ERR_NONE);
        ")":  add(KIND_CLOSE, 8'h00, 1'b0, 1'b1, ln, cl, ERR_NONE);
        ",":  add(KIND_COMMA, 8'h00, 1'b0, 1'b1, ln, cl, ERR_NONE);
        "'":  add(KIND_QUOTE, 8'h00, 1'b0, 1'b1, ln, cl, ERR_NONE);
        ".":  begin_at(SCAN_DOT, ln, cl);
        "-":  begin_at(SCAN_MINUS, ln, cl);
        ";":  mode = SCAN_COMMENT;
        "\"": begin_at(SCAN_STRING, ln, cl);
        default: begin
          if (is_digit(b)) begin
            begin_at(SCAN_NUMBER, ln, cl);
            seen_dot = 1'b0;
            value_char(KIND_INT, b, ERR_NONE);
          end else if (is_sym(b)) begin
            begin_at(SCAN_SYMBOL, ln, cl);
            value_char(KIND_SYMBOL, b, ERR_NONE);
          end else begin
            add(KIND_BAD, b, 1'b1, 1'b1, ln, cl, ERR_UNKNOWN_CHAR);
          end
        end
      endcase
    endfunction

    function void symbol_byte(logic [7:0] b, logic [23:0] ln, logic [15:0] cl);
      if (is_sym(b)) begin
        value_char(KIND_SYMBOL, b, ERR_NONE);
      end else begin
        value_end(KIND_SYMBOL, ERR_NONE);
        idle_byte(b, ln, cl);
      end
    endfunction

    // Called once per accepted source beat.
    function void note_byte(in_beat_t beat);
      logic [7:0]  b;
      logic [7:0]  ch;
      logic [23:0] ln;
      logic [15:0] cl;
      err_e        err;
      if (done) return;
      b  = beat.end_of_input ? 8'h00 : beat.source_byte;
      ln = line_cnt;
      cl = col_cnt;
      case (mode)
        SCAN_COMMENT: begin
          if (b == 8'h00 || b == "\n") idle_byte(b, ln, cl);
        end
        SCAN_STRING: begin
          if (b == 8'h00) begin
            value_end(KIND_STRING, ERR_UNTERMINATED);
            idle_byte(b, ln, cl);
          end else if (b == "\"") begin
            value_end(KIND_STRING, ERR_NONE);
          end else if (b == "\\") begin
            mode = SCAN_ESCAPE;
          end else if (b == "\n") begin
            value_char(KIND_STRING, b, ERR_NL_IN_STRING);
          end else begin
            value_char(KIND_STRING, b, ERR_NONE);
          end
        end
        SCAN_ESCAPE: begin
          if (b == 8'h00) begin
            value_end(KIND_STRING, ERR_UNTERMINATED);
            idle_byte(b, ln, cl);
          end else begin
            err = ERR_NONE;
            case (b)
              "n": ch = "\n";
              "t": ch = "\t";
              "r": ch = "\r";
              "\"", "'", "\\": ch = b;
              default: begin
                ch  = " ";
                err = ERR_BAD_ESCAPE;
              end
            endcase
            value_char(KIND_STRING, ch, err);
            mode = SCAN_STRING;
          end
        end
        SCAN_NUMBER: begin
          if (is_digit(b)) begin
            value_char(num_kind(), b, ERR_NONE);
          end else if (b == ".") begin
            err      = seen_dot ? ERR_SECOND_DOT : ERR_NONE;
            seen_dot = 1'b1;
            value_char(KIND_FLOAT, b, err);
          end else begin
            value_end(num_kind(), ERR_NONE);
            idle_byte(b, ln, cl);
          end
        end
        SCAN_SYMBOL: symbol_byte(b, ln, cl);
        SCAN_DOT: begin
          if (is_sym(b)) begin
            mode = SCAN_SYMBOL;
            value_char(KIND_SYMBOL, ".", ERR_NONE);
            value_char(KIND_SYMBOL, b, ERR_NONE);
          end else begin
            add(KIND_PERIOD, 8'h00, 1'b0, 1'b1, tok_line, tok_col, ERR_NONE);
            idle_byte(b, ln, cl);
          end
        end
        SCAN_MINUS: begin
          if (is_digit(b)) begin
            mode     = SCAN_NUMBER;
            seen_dot = 1'b0;
            value_char(KIND_INT, "-", ERR_NONE);
            value_char(KIND_INT, b, ERR_NONE);
          end else begin
            mode = SCAN_SYMBOL;
            value_char(KIND_SYMBOL, "-", ERR_NONE);
            symbol_byte(b, ln, cl);
          end
        end
        default: idle_byte(b, ln, cl);
      endcase
      // position of the next byte, both counters saturate
      if (!done) begin
        if (b == "\n") begin
          if (line_cnt != '1) line_cnt++;
          col_cnt = '0;
        end else if (col_cnt != '1) begin
          col_cnt++;
        end
      end
    endfunction

    function void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fail_cnt++;
      end
    endfunction

    // Called once per accepted token beat.
    function void check_token(out_beat_t got);
      out_beat_t want;
      if (expected_tokens.size() == 0) begin
        $error("token beat with nothing pending: kind %0d char %0d line %0d col %0d",
               got.token_kind, got.char_value, got.token_line, got.token_column);
        fail_cnt++;
        return;
      end
      want = expected_tokens.pop_front();
      check_field("token_kind", want.token_kind, got.token_kind);
      check_field("char_value", want.char_value, got.char_value);
      check_field("has_char", want.has_char, got.has_char);
      check_field("token_last", want.token_last, got.token_last);
      check_field("token_line", want.token_line, got.token_line);
      check_field("token_column", want.token_column, got.token_column);
      check_field("error_code", want.error_code, got.error_code);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_beat_t  in_beat   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_beat_t out_beat_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sexpr_token_scanner_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat_o)
  );

  token_scoreboard sb;
  in_beat_t        source_text[$];   // every source beat of the run, in order

  // --------------------------------------------------------------------------
  // Beat monitor. Samples pre-edge values, so stimulus NBAs at the same edge
  // never race with it. Token check goes first; a byte's tokens show up in
  // the cycle after the byte at the earliest, so order is only cosmetic.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall) sb.check_token(out_beat_o);
    if (in_valid && !in_stall_o) sb.note_byte(in_beat);
  end

  // --------------------------------------------------------------------------
  // Receiver stall pattern. Runs in phases (never stall, light, heavy,
  // periodic). Now and then, and once early for sure, it holds off for a long
  // stretch so that the result queue fills and the input gets stalled.
  // --------------------------------------------------------------------------
  int unsigned rx_cycle   = 0;
  int unsigned hold_left  = 0;
  int unsigned phase_left = 0;
  int unsigned rx_mode    = 0;

  always @(posedge clk_i) begin
    rx_cycle++;
    if (hold_left == 0 && (rx_cycle == 40 || $urandom_range(0, 1499) == 0))
      hold_left = $urandom_range(60, 100);
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        rx_mode    = $urandom_range(0, 3);
        phase_left = $urandom_range(10, 60);
      end
      phase_left--;
      case (rx_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (rx_cycle % 3 == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Source text construction
  // --------------------------------------------------------------------------
  task automatic put_char(logic [7:0] c);
    source_text.push_back('{source_byte: c, end_of_input: 1'b0});
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // Random nonzero byte outside the banned set; NUL would end the file.
  function automatic logic [7:0] rand_byte_not(string banned);
    logic [7:0] c;
    bit         hit;
    do begin
      c   = 8'($urandom_range(1, 255));
      hit = 1'b0;
      for (int i = 0; i < banned.len(); i++) if (banned[i] == c) hit = 1'b1;
    end while (hit);
    return c;
  endfunction

  function automatic logic [7:0] rand_symbol();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (!sb.is_sym(c));
    return c;
  endfunction

  // One random token, mostly well formed, followed maybe by a separator.
  // No separator means adjacent tokens, which is where multi-result bytes
  // come from.
  task automatic gen_token();
    int unsigned n;
    case ($urandom_range(0, 11))
      0: repeat ($urandom_range(1, 3)) put_char(pick(" \t\r\n"));
      1: put_char(pick("()"));
      2: put_char(pick(",'"));
      3, 4: begin
        if ($urandom_range(0, 2) == 0) put_char("-");
        repeat ($urandom_range(1, 4)) put_char(pick("0123456789"));
        if ($urandom_range(0, 1) == 1) begin
          put_char(".");
          repeat ($urandom_range(0, 3)) put_char(pick("0123456789"));
          if ($urandom_range(0, 4) == 0) begin
            put_char(".");
            put_char(pick("0123456789"));
          end
        end
      end
      5, 6: begin
        // a lone lead '.' or '-' (n hits zero) gives period / minus symbol
        n = $urandom_range(1, 5);
        case ($urandom_range(0, 3))
          0: begin
            put_char(".");
            n--;
          end
          1: begin
            put_char("-");
            n--;
          end
          default: ;
        endcase
        repeat (n) put_char(rand_symbol());
      end
      7: begin
        put_char("\"");
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 11))
            0, 1: begin
              put_char("\\");
              put_char(pick("ntr\"'\\x0Q "));
            end
            2:       put_char("\n");
            default: put_char(rand_byte_not("\"\\\n"));
          endcase
        end
        put_char("\"");
      end
      8: begin
        put_char(";");
        repeat ($urandom_range(0, 8)) put_char(rand_byte_not("\n"));
        put_char("\n");
      end
      9:       put_char(pick("[]|\\#"));
      default: put_char(rand_byte_not(""));
    endcase
    case ($urandom_range(0, 3))
      0:       put_char(" ");
      1:       put_char("\n");
      default: ;
    endcase
  endtask

  task automatic build_source();
    int unsigned target;
    // Opening: open, '-' then '(' (three tokens from one byte), period then
    // close, dot-led symbol, number with a second dot, string with a bad
    // escape, a good escape and a raw newline, unknown char, high-byte
    // symbol, quote, comma, comment, close.
    put_text("(-(.).a -7.1.\"\\q\\n\n\"[");
    put_char(8'hFF);
    put_text(" ',;c\n)");
    // two stretches of random tokens around a short fixed line
    target = source_text.size() + 95;
    while (source_text.size() < target) gen_token();
    put_text("(k -8)");
    target = source_text.size() + 95;
    while (source_text.size() < target) gen_token();
    // random ending: leaves the scanner in one of its states at end of file
    case ($urandom_range(0, 7))
      0: ;
      1: put_text("\"ab");
      2: put_text("\"x\\");
      3: put_text("; tail");
      4: put_text("42");
      5: put_text("sym");
      6: put_text(".");
      default: put_text("-");
    endcase
    if ($urandom_range(0, 1) == 1)
      source_text.push_back('{source_byte: 8'h00, end_of_input: 1'b0});
    else
      source_text.push_back('{source_byte: 8'($urandom_range(0, 255)), end_of_input: 1'b1});
    // after end of file everything is swallowed
    repeat ($urandom_range(3, 6))
      source_text.push_back('{source_byte: 8'($urandom_range(0, 255)),
                              end_of_input: 1'($urandom_range(0, 1))});
  endtask

  // --------------------------------------------------------------------------
  // Source driver: bursts of random length with random gaps between them.
  // Valid only drops at a gap or the end, never within the same edge it rises.
  // --------------------------------------------------------------------------
  task automatic send_beat(in_beat_t beat);
    in_valid <= 1'b1;
    in_beat  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drive_source();
    int unsigned burst_left;
    int unsigned gap;
    burst_left = 0;
    foreach (source_text[i]) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 24);
      end
      send_beat(source_text[i]);
      burst_left--;
    end
    in_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    build_source();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    drive_source();
    // drain, then give stray beats a chance to show up
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.fail_cnt == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (a few hundred bytes, bursts,
  // holds).
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
design/sts_pkg.sv
design/sts_core.sv
design/sts_res_fifo.sv
design/sexpr_token_scanner_top.sv
dv/tb_sexpr_token_scanner_top.sv
